/* src/dqid_pkg.sv */
// ----------------------------------------------------------------------------
// dqid_pkg
// Shared constants, command codes, control/status bundles and the circular
// slot helper for the deque with indexed delete.
// ----------------------------------------------------------------------------
package dqid_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int POS_W    = 16;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd2;

   typedef struct packed {
      logic accept;
      logic shift_rd;
      logic shift_wr;
      logic emit_init;
      logic emit_rd;
      logic emit_ld;
   } ctrl_type;

   typedef struct packed {
      logic shift_more;
      logic out_free;
      logic emit_last;
   } stat_type;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

/* src/deque_with_indexed_delete_unit.sv */
// Sequence: after accept, each entry behind a middle-removed position is
// moved by a read and a write; then each result word is read and loaded,
// waiting while the output word is stalled. The next command is taken only
// after the last word is loaded, set by the store's single registered read port.
// Reset: synchronous, clears count, front pointer and state; store unset.
// ----------------------------------------------------------------------------
// deque_with_indexed_delete_unit
// Ordered store of signed words with push front, push back and indexed
// delete; emits the whole sequence after every command.
// ----------------------------------------------------------------------------
module deque_with_indexed_delete_unit
   import dqid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_is_last,
   output logic                     rsp_list_empty,
   output logic                     rsp_overflow
);

   ctrl_type ctrl;
   stat_type stat;

   dqid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   dqid_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_element    (rsp_element),
      .rsp_is_last    (rsp_is_last),
      .rsp_list_empty (rsp_list_empty),
      .rsp_overflow   (rsp_overflow),
      .ctrl           (ctrl),
      .stat           (stat)
   );

endmodule

/* src/dqid_ctrl.sv */
// ----------------------------------------------------------------------------
// dqid_ctrl
// Sequencer: accepts one command, walks the removal shift, then walks the
// emission of the whole sequence through the datapath.
// ----------------------------------------------------------------------------
module dqid_ctrl
   import dqid_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output ctrl_type ctrl,
   input  stat_type stat
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SHIFT_RD = 5'b00010,
      ST_SHIFT_WR = 5'b00100,
      ST_EMIT_RD  = 5'b01000,
      ST_EMIT_LD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.accept = 1'b1;
               state_in    = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (stat.shift_more) begin
               ctrl.shift_rd = 1'b1;
               state_in      = ST_SHIFT_WR;
            end else begin
               ctrl.emit_init = 1'b1;
               state_in       = ST_EMIT_RD;
            end
         end
         ST_SHIFT_WR: begin
            ctrl.shift_wr = 1'b1;
            state_in      = ST_SHIFT_RD;
         end
         ST_EMIT_RD: begin
            ctrl.emit_rd = 1'b1;
            state_in     = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (stat.out_free) begin
               ctrl.emit_ld = 1'b1;
               state_in     = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/dqid_dpath.sv */
// ----------------------------------------------------------------------------
// dqid_dpath
// Circular entry store, front pointer, count, walk index and the result
// word register.
// ----------------------------------------------------------------------------
module dqid_dpath
   import dqid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_is_last,
   output logic                     rsp_list_empty,
   output logic                     rsp_overflow,
   input  ctrl_type                 ctrl,
   output stat_type                 stat
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   logic [IDX_W-1:0]  fp_ff, fp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              mid_ff, mid_in;
   logic              ovf_ff, ovf_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] element_ff;
   logic              last_ff, empty_ff, rovf_ff;

   logic              full, is_push, rm_hit, empty;
   logic [IDX_W-1:0]  fp_dec, back_slot, cur_slot, next_slot;
   logic [CNT_W-1:0]  idx_inc;
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign is_push   = (req_command == CMD_PUSH_FRONT) || (req_command == CMD_PUSH_BACK);
   assign rm_hit    = (req_command == CMD_REMOVE) && (req_position < POS_W'(count_ff));
   assign fp_dec    = (fp_ff == '0) ? IDX_W'(CAPACITY - 1) : fp_ff - IDX_W'(1);
   assign back_slot = wrap_add(fp_ff, count_ff[IDX_W-1:0]);
   assign idx_inc   = idx_ff + CNT_W'(1);
   assign cur_slot  = wrap_add(fp_ff, idx_ff[IDX_W-1:0]);
   assign next_slot = wrap_add(fp_ff, idx_inc[IDX_W-1:0]);

   assign stat.shift_more = mid_ff && (idx_ff < count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.emit_last  = empty || (idx_inc == count_ff);

   always_comb begin
      fp_in        = fp_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      mid_in       = mid_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_slot;
      wr_data      = rd_data_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_slot;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (ctrl.accept) begin
         mid_in = 1'b0;
         ovf_in = is_push && full;
         idx_in = CNT_W'(req_position);
         if (is_push && !full) begin
            wr_en    = 1'b1;
            wr_data  = req_value;
            count_in = count_ff + CNT_W'(1);
            if (req_command == CMD_PUSH_FRONT) begin
               wr_addr = fp_dec;
               fp_in   = fp_dec;
            end else begin
               wr_addr = back_slot;
            end
         end else if (rm_hit) begin
            count_in = count_ff - CNT_W'(1);
            if (req_position == '0) begin
               fp_in = wrap_add(fp_ff, IDX_W'(1));
            end else begin
               mid_in = 1'b1;
            end
         end
      end

      if (ctrl.shift_rd) begin
         rd_en   = 1'b1;
         rd_addr = next_slot;
      end

      if (ctrl.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = cur_slot;
         wr_data = rd_data_ff;
         idx_in  = idx_inc;
      end

      if (ctrl.emit_init) begin
         idx_in = '0;
         mid_in = 1'b0;
      end

      if (ctrl.emit_rd) begin
         rd_en   = 1'b1;
         rd_addr = cur_slot;
      end

      if (ctrl.emit_ld) begin
         rsp_valid_in = 1'b1;
         idx_in       = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_ld) begin
         element_ff <= empty ? '0 : rd_data_ff;
         last_ff    <= stat.emit_last;
         empty_ff   <= empty;
         rovf_ff    <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff        <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         mid_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fp_ff        <= fp_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         mid_ff       <= mid_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_element    = element_ff;
   assign rsp_is_last    = last_ff;
   assign rsp_list_empty = empty_ff;
   assign rsp_overflow   = rovf_ff;

endmodule

/* src/dqid_checker.sv */
// ----------------------------------------------------------------------------
// dqid_checker
// Port-level checks on the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module dqid_checker
   import dqid_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_element,
   input logic                     rsp_is_last,
   input logic                     rsp_list_empty
);

   empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |-> rsp_is_last)
      else $error("empty word not marked last");

   empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |-> rsp_element == '0)
      else $error("empty word carries nonzero element");

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken before first finished");

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element))
      else $error("stalled result word changed");

endmodule

bind deque_with_indexed_delete_unit dqid_checker u_dqid_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_element    (rsp_element),
   .rsp_is_last    (rsp_is_last),
   .rsp_list_empty (rsp_list_empty)
);
